### hdl/slot_mask_table_macros.svh
// Assertion macros shared by the slot mask table RTL.
`ifndef SLOT_MASK_TABLE_MACROS_SVH
`define SLOT_MASK_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is held.
`define SMT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("slot_mask_table: assertion failed");

// Check a property on every rising edge, reset included.
`define SMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("slot_mask_table: assertion failed");

`else

`define SMT_ASSERT(lbl, clk, rst_n, prop)
`define SMT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### hdl/smt_pkg.sv
package smt_pkg;

    // Field widths of the request and response items
    localparam int OP_W   = 3;
    localparam int SLOT_W = 6;
    localparam int BITS_W = 32;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_ADD     = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_EXISTS  = 3'd4,
        OP_HAS     = 3'd5
    } t_op;

    // Flags from the mask update unit to the sequencer
    typedef struct packed {
        logic wr_en;
        logic is_free;
        logic answer;
    } t_unit_flags;

endpackage

### hdl/smt_req_if.sv
interface smt_req_if import smt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [BITS_W-1:0] bits;

    modport source (output valid, output operation, output slot, output bits, input ready);
    modport sink   (input valid, input operation, input slot, input bits, output ready);
endinterface

### hdl/smt_rsp_if.sv
interface smt_rsp_if import smt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] new_slot;
    logic              answer;
    logic              full_res;

    modport source (output valid, output new_slot, output answer, output full_res, input ready);
    modport sink   (input valid, input new_slot, input answer, input full_res, output ready);
endinterface

### hdl/smt_ram.sv
module smt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry, read one entry into a register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/smt_unit.sv
module smt_unit import smt_pkg::*; #(
    parameter int MASK_BITS = 32
) (
    input  t_op                  i_op,
    input  logic [MASK_BITS-1:0] i_mask,
    input  logic [MASK_BITS-1:0] i_bits,
    output logic [MASK_BITS-1:0] o_wr_mask,
    output t_unit_flags          o_flags
);

    localparam logic [MASK_BITS-1:0] LiveBit = MASK_BITS'(1);

    logic w_free;

    assign w_free = (i_mask == '0);

    // Work out the new mask and the answer for one stored entry
    always_comb begin
        o_wr_mask       = i_mask;
        o_flags.wr_en   = 1'b0;
        o_flags.is_free = w_free;
        o_flags.answer  = 1'b0;
        case (i_op)
            OP_CREATE: begin
                o_wr_mask     = LiveBit;
                o_flags.wr_en = w_free;
            end
            OP_DESTROY: begin
                o_wr_mask     = '0;
                o_flags.wr_en = 1'b1;
            end
            OP_ADD: begin
                o_wr_mask     = i_mask | i_bits;
                o_flags.wr_en = 1'b1;
            end
            OP_REMOVE: begin
                o_wr_mask     = i_mask & ~i_bits;
                o_flags.wr_en = 1'b1;
            end
            OP_EXISTS: begin
                o_flags.answer = !w_free;
            end
            OP_HAS: begin
                o_flags.answer = ((i_mask & i_bits) == i_bits);
            end
            default: begin
                o_flags.wr_en = 1'b0;
            end
        endcase
    end

endmodule

### hdl/slot_mask_table.sv
// Channel  Modport      Payload                          Handshake
// i_req    sink         operation, slot, bits            valid / ready
// o_rsp    source       new_slot, answer, full_res       valid / ready
//
// One request at a time. Destroy, add, remove, exists and has go through these steps from
// accept to result: accept, read the slot, update it in the mask unit, load the result.
// An undefined operation or an out-of-range slot skips the store. Create scans from slot 0,
// reading and evaluating each slot in turn until a free slot is found or the last is examined.
// After reset a clearing pass zeroes every slot with i_req.ready low.
// A stalled o_rsp holds one result; the next request is accepted and waits at its end.
`include "slot_mask_table_macros.svh"

module slot_mask_table import smt_pkg::*; #(
    parameter int SLOT_COUNT = 64,
    parameter int MASK_BITS  = 32
) (
    input logic      i_clk,
    input logic      i_rst_n,
    smt_req_if.sink  i_req,
    smt_rsp_if.source o_rsp
);

    localparam int IdxW = $clog2(SLOT_COUNT);
    localparam int InW  = (MASK_BITS < BITS_W) ? MASK_BITS : BITS_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EV,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [IdxW-1:0]       r_idx, n_idx;
    t_op                   r_op, n_op;
    logic [MASK_BITS-1:0]  r_bits, n_bits;
    logic [SLOT_W-1:0]     r_new_slot, n_new_slot;
    logic                  r_answer, n_answer;
    logic                  r_full, n_full;
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic                  r_out_answer, n_out_answer;
    logic                  r_out_full, n_out_full;

    logic                  w_accept;
    logic                  w_slot_ok;
    logic [MASK_BITS-1:0]  w_rd_mask;
    logic [MASK_BITS-1:0]  w_unit_mask;
    t_unit_flags           w_flags;
    logic                  w_we;
    logic [MASK_BITS-1:0]  w_wr_data;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_ok   = (32'(i_req.slot) < SLOT_COUNT);

    // Slot mask store
    smt_ram #(
        .WIDTH (MASK_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_mask)
    );

    // Shared mask update and test unit
    smt_unit #(
        .MASK_BITS (MASK_BITS)
    ) u_unit (
        .i_op      (r_op),
        .i_mask    (w_rd_mask),
        .i_bits    (r_bits),
        .o_wr_mask (w_unit_mask),
        .o_flags   (w_flags)
    );

    // Write zero during the clearing pass, the unit's mask while evaluating
    always_comb begin
        w_we      = 1'b0;
        w_wr_data = w_unit_mask;
        if (r_state == S_CLEAR) begin
            w_we      = 1'b1;
            w_wr_data = '0;
        end else if (r_state == S_EV) begin
            w_we = w_flags.wr_en;
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_op         = r_op;
        n_bits       = r_bits;
        n_new_slot   = r_new_slot;
        n_answer     = r_answer;
        n_full       = r_full;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_slot   = r_out_slot;
        n_out_answer = r_out_answer;
        n_out_full   = r_out_full;
        case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LastIdx) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op       = t_op'(i_req.operation);
                    n_bits     = MASK_BITS'(i_req.bits[InW-1:0]);
                    n_new_slot = '0;
                    n_answer   = 1'b0;
                    n_full     = 1'b0;
                    if (n_op == OP_CREATE) begin
                        n_idx   = '0;
                        n_state = S_RD;
                    end else if ((n_op inside {OP_DESTROY, OP_ADD, OP_REMOVE,
                                               OP_EXISTS, OP_HAS}) && w_slot_ok) begin
                        n_idx   = IdxW'(i_req.slot);
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = S_DONE;
                if (r_op == OP_CREATE) begin
                    if (w_flags.is_free) begin
                        n_new_slot = SLOT_W'(r_idx);
                    end else if (r_idx == LastIdx) begin
                        n_full = 1'b1;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    n_answer = w_flags.answer;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_new_slot;
                    n_out_answer = r_answer;
                    n_out_full   = r_full;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, request fields and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_bits       <= n_bits;
        r_new_slot   <= n_new_slot;
        r_answer     <= n_answer;
        r_full       <= n_full;
        r_out_slot   <= n_out_slot;
        r_out_answer <= n_out_answer;
        r_out_full   <= n_out_full;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.new_slot = r_out_slot;
    assign o_rsp.answer   = r_out_answer;
    assign o_rsp.full_res = r_out_full;

    // A full create reports slot zero and no answer
    `SMT_ASSERT(a_full_clean, i_clk, i_rst_n, r_out_valid && r_out_full |-> r_out_slot == '0)
    // Only the clearing pass and the evaluate step write the store
    `SMT_ASSERT(a_write_state, i_clk, i_rst_n, w_we |-> (r_state == S_CLEAR || r_state == S_EV))
    // An accepted request closes the input until its result is loaded
    `SMT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_accept |=> !i_req.ready)
    // The clearing pass keeps the input closed
    `SMT_ASSERT_ALWAYS(a_clear_closed, i_clk, (r_state == S_CLEAR) |-> !i_req.ready)

endmodule
